@@ hdl/rle2i_pkg.sv @@
package rle2i_pkg;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic              group_valid;
		logic signed [11:0] pixel_x;
		logic [11:0]       pixel_y;
		logic [7:0]        pixel_colors;
		logic              double_width;
		logic              run_pending;
		logic              image_done;
	} out_t;

	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_CONT    = 2'd1,
		OP_RESTART = 2'd2,
		OP_NOP     = 2'd3
	} op_code_t;

	typedef struct packed {
		op_code_t   op;
		logic [7:0] data;
	} op_t;

	localparam logic [15:0] HDR_LEN       = 16'h0017;
	localparam logic [15:0] HDR_SIZE_LO   = 16'h0005;
	localparam logic [15:0] HDR_SIZE_HI   = 16'h0006;
	localparam logic [15:0] HDR_LINED     = 16'h000d;
	localparam logic [15:0] HDR_START_LO  = 16'h000f;
	localparam logic [15:0] HDR_START_HI  = 16'h0010;
	localparam logic [15:0] HDR_END_LO    = 16'h0011;
	localparam logic [15:0] HDR_END_HI    = 16'h0012;
	localparam logic [15:0] HDR_WIDTH     = 16'h0013;
	localparam logic [15:0] POS_MAX       = 16'hffff;
	localparam logic [7:0]  LINED_MARK    = 8'hff;
	localparam logic [15:0] RECIP_DIV40   = 16'd52429;
	localparam logic [15:0] RECIP_DIV80   = 16'd52429;
	localparam logic signed [11:0] ORIGIN_X_BIAS = 12'sd24;

endpackage

@@ hdl/rle2i_front.sv @@
module rle2i_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  rle2i_pkg::in_t    item,
	input  logic              queue_full,
	output logic              push,
	output rle2i_pkg::op_t    push_word
);

	logic           valid_s1;
	rle2i_pkg::op_t op_s1;
	rle2i_pkg::op_t op_dec;

	always_comb begin
		op_dec.data = item.data_byte;
		unique case (item.req_type)
			rle2i_pkg::OP_BYTE:    op_dec.op = rle2i_pkg::OP_BYTE;
			rle2i_pkg::OP_CONT:    op_dec.op = rle2i_pkg::OP_CONT;
			rle2i_pkg::OP_RESTART: op_dec.op = rle2i_pkg::OP_RESTART;
			default:               op_dec.op = rle2i_pkg::OP_NOP;
		endcase
	end

	assign item_stall = valid_s1 & queue_full;
	assign push       = valid_s1 & ~queue_full;
	assign push_word  = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1    <= '0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
			op_s1    <= op_dec;
		end
	end

endmodule

@@ hdl/rle2i_queue.sv @@
module rle2i_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rle2i_pkg::op_t push_word,
	output logic           full,
	input  logic           pop,
	output rle2i_pkg::op_t pop_word,
	output logic           empty
);

	rle2i_pkg::op_t mem [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_word = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hdl/rle2i_back.sv @@
module rle2i_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            queue_empty,
	input  rle2i_pkg::op_t  queue_word,
	output logic            pop,
	output logic            result_valid,
	input  logic            result_stall,
	output rle2i_pkg::out_t result
);

	typedef enum logic [1:0] {
		MODE_COUNT   = 2'd0,
		MODE_REPEAT  = 2'd1,
		MODE_LITERAL = 2'd2,
		MODE_RUN     = 2'd3
	} mode_t;

	logic [15:0]        byte_pos_q;
	logic [15:0]        image_size_q;
	logic               lined_q;
	logic [15:0]        start_q;
	logic [7:0]         end_lo_q;
	logic signed [11:0] origin_x_q;
	logic [11:0]        origin_y_q;
	logic signed [10:0] line_limit_q;
	logic [9:0]         line_width_q;
	logic signed [11:0] cursor_x_q;
	logic [11:0]        cursor_y_q;
	logic [10:0]        line_count_q;
	logic [1:0]         fields_q;
	mode_t              mode_q;
	logic [7:0]         remain_q;
	logic [7:0]         pattern_q;
	logic               done_q;
	logic               out_valid_q;
	rle2i_pkg::out_t    out_q;

	logic [15:0]        byte_pos_d;
	logic [15:0]        image_size_d;
	logic               lined_d;
	logic [15:0]        start_d;
	logic [7:0]         end_lo_d;
	logic signed [11:0] origin_x_d;
	logic [11:0]        origin_y_d;
	logic signed [10:0] line_limit_d;
	logic [9:0]         line_width_d;
	logic signed [11:0] cursor_x_d;
	logic [11:0]        cursor_y_d;
	logic [10:0]        line_count_d;
	logic [1:0]         fields_d;
	mode_t              mode_d;
	logic [7:0]         remain_d;
	logic [7:0]         pattern_d;
	logic               done_d;
	rle2i_pkg::out_t    out_d;

	logic signed [12:0] pl_cx_add;
	logic signed [12:0] pl_lim;
	logic signed [11:0] pl_cx;
	logic [11:0]        pl_cy;
	logic [11:0]        pl_lc_inc;
	logic [10:0]        pl_lc;
	logic [1:0]         pl_ff;

	logic [15:0]        so_new;
	logic [31:0]        prod40;
	logic [9:0]         q80;
	logic [15:0]        q80_x80;
	logic [15:0]        r80;
	logic [16:0]        diff;
	logic [15:0]        diff_abs;
	logic [31:0]        prod80;
	logic [10:0]        lim_mag;
	logic [7:0]         b;

	assign pop          = ~queue_empty & (~out_valid_q | ~result_stall);
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign b            = queue_word.data;

	always_comb begin
		pl_cx_add = {cursor_x_q[11], cursor_x_q} + (lined_q ? 13'sd8 : 13'sd4);
		pl_lim    = {origin_x_q[11], origin_x_q} + $signed({3'b000, line_width_q});
		pl_cx     = pl_cx_add[11:0];
		pl_cy     = cursor_y_q;
		pl_lc_inc = {1'b0, line_count_q};
		pl_ff     = fields_q;
		if (pl_cx_add >= pl_lim) begin
			pl_cy     = cursor_y_q + 12'd2;
			pl_cx     = origin_x_q;
			pl_lc_inc = {1'b0, line_count_q} + 12'd1;
		end
		pl_lc = pl_lc_inc[10:0];
		if ($signed({1'b0, pl_lc_inc}) > $signed({{2{line_limit_q[10]}}, line_limit_q})) begin
			pl_cy = origin_y_q + 12'd1;
			pl_ff = (fields_q == 2'd3) ? 2'd3 : fields_q + 2'd1;
			pl_lc = '0;
		end
	end

	always_comb begin
		so_new   = {b, start_q[7:0]};
		prod40   = so_new * rle2i_pkg::RECIP_DIV40;
		q80      = prod40[31:22];
		q80_x80  = {q80, 6'b0} + {2'b00, q80, 4'b0};
		r80      = so_new - q80_x80;
		diff     = {1'b0, b, end_lo_q} - {1'b0, start_q};
		diff_abs = diff[16] ? (~diff[15:0] + 16'd1) : diff[15:0];
		prod80   = diff_abs * rle2i_pkg::RECIP_DIV80;
		lim_mag  = {1'b0, prod80[31:22]};
	end

	always_comb begin
		byte_pos_d   = byte_pos_q;
		image_size_d = image_size_q;
		lined_d      = lined_q;
		start_d      = start_q;
		end_lo_d     = end_lo_q;
		origin_x_d   = origin_x_q;
		origin_y_d   = origin_y_q;
		line_limit_d = line_limit_q;
		line_width_d = line_width_q;
		cursor_x_d   = cursor_x_q;
		cursor_y_d   = cursor_y_q;
		line_count_d = line_count_q;
		fields_d     = fields_q;
		mode_d       = mode_q;
		remain_d     = remain_q;
		pattern_d    = pattern_q;
		done_d       = done_q;
		out_d        = '0;

		unique case (queue_word.op)
			rle2i_pkg::OP_RESTART: begin
				byte_pos_d   = '0;
				image_size_d = '0;
				lined_d      = 1'b0;
				start_d      = '0;
				end_lo_d     = '0;
				origin_x_d   = '0;
				origin_y_d   = '0;
				line_limit_d = '0;
				line_width_d = '0;
				cursor_x_d   = '0;
				cursor_y_d   = '0;
				line_count_d = '0;
				fields_d     = '0;
				mode_d       = MODE_COUNT;
				remain_d     = '0;
				pattern_d    = '0;
				done_d       = 1'b0;
			end
			rle2i_pkg::OP_CONT: begin
				if (!done_q && mode_q == MODE_RUN) begin
					out_d.group_valid  = 1'b1;
					out_d.pixel_x      = cursor_x_q;
					out_d.pixel_y      = cursor_y_q;
					out_d.pixel_colors = pattern_q;
					cursor_x_d   = pl_cx;
					cursor_y_d   = pl_cy;
					line_count_d = pl_lc;
					fields_d     = pl_ff;
					if (remain_q != 8'd0) begin
						remain_d = remain_q - 8'd1;
					end
					if (remain_q <= 8'd1) begin
						mode_d = MODE_COUNT;
						if (byte_pos_q >= image_size_q || pl_ff >= 2'd2) begin
							done_d = 1'b1;
						end
					end
				end
			end
			rle2i_pkg::OP_BYTE: begin
				if (!done_q && mode_q != MODE_RUN) begin
					if (byte_pos_q != rle2i_pkg::POS_MAX) begin
						byte_pos_d = byte_pos_q + 16'd1;
					end
					if (byte_pos_q < rle2i_pkg::HDR_LEN) begin
						unique case (byte_pos_q)
							rle2i_pkg::HDR_SIZE_LO:  image_size_d = {image_size_q[15:8], b};
							rle2i_pkg::HDR_SIZE_HI:  image_size_d = {b, image_size_q[7:0]};
							rle2i_pkg::HDR_LINED:    lined_d = (b == rle2i_pkg::LINED_MARK);
							rle2i_pkg::HDR_START_LO: start_d = {start_q[15:8], b};
							rle2i_pkg::HDR_START_HI: begin
								start_d    = so_new;
								origin_x_d = $signed({3'b000, r80[6:0], 2'b00})
									- rle2i_pkg::ORIGIN_X_BIAS;
								origin_y_d = {1'b0, prod40[31:22], 1'b0};
								cursor_x_d = $signed({3'b000, r80[6:0], 2'b00})
									- rle2i_pkg::ORIGIN_X_BIAS;
								cursor_y_d = {1'b0, prod40[31:22], 1'b0};
							end
							rle2i_pkg::HDR_END_LO:   end_lo_d = b;
							rle2i_pkg::HDR_END_HI:   line_limit_d = diff[16] ?
								$signed(~lim_mag + 11'd1) : $signed(lim_mag);
							rle2i_pkg::HDR_WIDTH:    line_width_d = {b, 2'b00};
							default: ;
						endcase
						if (byte_pos_q == rle2i_pkg::HDR_LEN - 16'd1) begin
							mode_d = MODE_COUNT;
							if (byte_pos_d >= image_size_d || fields_q >= 2'd2) begin
								done_d = 1'b1;
							end
						end
					end else begin
						unique case (mode_q)
							MODE_COUNT: begin
								if (b[7]) begin
									mode_d   = MODE_REPEAT;
									remain_d = {1'b0, b[6:0]};
								end else begin
									mode_d   = MODE_LITERAL;
									remain_d = b + 8'd1;
								end
							end
							MODE_REPEAT: begin
								pattern_d          = b;
								out_d.group_valid  = 1'b1;
								out_d.pixel_x      = cursor_x_q;
								out_d.pixel_y      = cursor_y_q;
								out_d.pixel_colors = b;
								cursor_x_d   = pl_cx;
								cursor_y_d   = pl_cy;
								line_count_d = pl_lc;
								fields_d     = pl_ff;
								if (remain_q == 8'd0) begin
									mode_d = MODE_COUNT;
									if (byte_pos_d >= image_size_q || pl_ff >= 2'd2) begin
										done_d = 1'b1;
									end
								end else begin
									mode_d = MODE_RUN;
								end
							end
							default: begin
								out_d.group_valid  = 1'b1;
								out_d.pixel_x      = cursor_x_q;
								out_d.pixel_y      = cursor_y_q;
								out_d.pixel_colors = b;
								cursor_x_d   = pl_cx;
								cursor_y_d   = pl_cy;
								line_count_d = pl_lc;
								fields_d     = pl_ff;
								if (remain_q != 8'd0) begin
									remain_d = remain_q - 8'd1;
								end
								if (remain_q <= 8'd1) begin
									mode_d = MODE_COUNT;
									if (byte_pos_d >= image_size_q || pl_ff >= 2'd2) begin
										done_d = 1'b1;
									end
								end
							end
						endcase
					end
				end
			end
			default: ;
		endcase

		out_d.double_width = lined_d;
		out_d.run_pending  = (mode_d == MODE_RUN);
		out_d.image_done   = done_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q   <= '0;
			image_size_q <= '0;
			lined_q      <= 1'b0;
			start_q      <= '0;
			end_lo_q     <= '0;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			line_limit_q <= '0;
			line_width_q <= '0;
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			line_count_q <= '0;
			fields_q     <= '0;
			mode_q       <= MODE_COUNT;
			remain_q     <= '0;
			pattern_q    <= '0;
			done_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (pop) begin
				byte_pos_q   <= byte_pos_d;
				image_size_q <= image_size_d;
				lined_q      <= lined_d;
				start_q      <= start_d;
				end_lo_q     <= end_lo_d;
				origin_x_q   <= origin_x_d;
				origin_y_q   <= origin_y_d;
				line_limit_q <= line_limit_d;
				line_width_q <= line_width_d;
				cursor_x_q   <= cursor_x_d;
				cursor_y_q   <= cursor_y_d;
				line_count_q <= line_count_d;
				fields_q     <= fields_d;
				mode_q       <= mode_d;
				remain_q     <= remain_d;
				pattern_q    <= pattern_d;
				done_q       <= done_d;
				out_q        <= out_d;
				out_valid_q  <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/rle_2bpp_interlaced_image_decoder.sv @@
// Run-length decoder for 2-bit-per-pixel interlaced images.
// Item channel (item_valid / item_stall / item): one word per file byte,
// continue request, restart request or no-op. Result channel
// (result_valid / result_stall / result): exactly one word per item, in
// order, carrying a pixel group when one is placed plus the status flags.
// A word moves at a rising edge where valid is high and stall is low.
// Path: an item is held in the decode register from the edge that
// accepts it, then passes through the queue into the result register.
// Throughput: one item per cycle; the back end updates all decoder state
// for each item in one step, so nothing limits the rate but the stalls.
// When the result receiver stalls, the result register holds, the queue
// fills, and item_stall rises once the queue and decode register are full;
// no word is dropped or repeated.
// Reset (arst_n low) clears the queue and all decoder state: the decoder
// then waits for a new 23-byte header; a restart resets decoder state in-band.
module rle_2bpp_interlaced_image_decoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  rle2i_pkg::in_t  item,
	output logic            result_valid,
	input  logic            result_stall,
	output rle2i_pkg::out_t result
);

	logic           push;
	logic           pop;
	logic           queue_full;
	logic           queue_empty;
	rle2i_pkg::op_t push_word;
	rle2i_pkg::op_t pop_word;

	rle2i_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.queue_full (queue_full),
		.push       (push),
		.push_word  (push_word)
	);

	rle2i_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (queue_full),
		.pop       (pop),
		.pop_word  (pop_word),
		.empty     (queue_empty)
	);

	rle2i_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_empty  (queue_empty),
		.queue_word   (pop_word),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
